// ----- hw/rtl/ray_sphere_intersect_unit_assert.svh -----
// Assertion macros shared by the ray-sphere intersection RTL.
`ifndef RAY_SPHERE_INTERSECT_UNIT_ASSERT_SVH
`define RAY_SPHERE_INTERSECT_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define RSI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define RSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ----- hw/rtl/rsi_pkg.sv -----
// Shared widths, constants and beat types of the ray-sphere intersection unit.
package rsi_pkg;

   localparam int FRAC_BITS = 16;

   localparam int COORD_W = 32;
   localparam int RAD_W   = 31;
   localparam int OC_W    = COORD_W + 1;
   localparam int DD_W    = 2 * COORD_W;
   localparam int OD_W    = OC_W + COORD_W;
   localparam int OO_W    = 2 * OC_W;
   localparam int RR_W    = 2 * RAD_W;
   localparam int A_W     = 64;
   localparam int HB_W    = 66;
   localparam int C_W     = 67;
   localparam int HBM_W   = HB_W - 1;
   localparam int CM_W    = C_W - 1;
   localparam int HL_W    = 33;
   localparam int HH_W    = HBM_W - HL_W;
   localparam int AL_W    = 32;
   localparam int AH_W    = A_W - AL_W;
   localparam int CL_W    = 33;
   localparam int CH_W    = CM_W - CL_W;
   localparam int PROD_W  = 130;
   localparam int DISC_W  = 132;
   localparam int SQ_W    = DISC_W / 2;
   localparam int SUM_W   = 68;
   localparam int MAG_W   = SUM_W - 1;
   localparam int Q_W     = 32;
   localparam int NN_W    = MAG_W + FRAC_BITS;
   localparam int HI_W    = NN_W - Q_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_W = 320;
   localparam int RSP_DATA_W = 40;

   localparam logic [Q_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [Q_W-1:0] NEG_LIMIT = 32'h8000_0000;
   localparam logic [Q_W-1:0] MINUS_ONE = Q_W'(-(64'sd1 <<< FRAC_BITS));

   // Item handed from the classifying front to the root/divide back
   typedef struct packed {
      logic [DISC_W-1:0]      disc;
      logic signed [HB_W-1:0] hb;
      logic [A_W-1:0]         a;
      logic                   hit;
      logic                   degen;
   } front_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic           saturated;
      logic           degenerate;
      logic [Q_W-1:0] hit_distance;
      logic           hit;
   } rsp_beat_type;

endpackage

// ----- hw/rtl/ray_sphere_intersect_unit.sv -----
// Path from an accepted req beat to its rsp beat: 7 front stages, a queue slot, 67 root stages,
// the numerator stages, the divide stages and 1 output register.
// Throughput: one beat per cycle unless stalled; each integer root and quotient bit has its own stage.
// The 4-entry queue lets the front keep accepting while the rsp side is stalled, until it fills.
// Reset (synchronous, active high) clears all valid bits and the queue; data is not cleared.
`include "ray_sphere_intersect_unit_assert.svh"

module ray_sphere_intersect_unit
   import rsi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, center_x, center_y,
   // center_z (32 bits each), sphere_radius (31 bits), one zero pad bit
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hit, hit_distance (32 bits), degenerate, saturated, five zero pad bits
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic             front_valid, front_ready;
   front_item_type   front_item;
   logic             back_valid, back_ready;
   front_item_type   back_item;
   queue_status_type qstat;

   rsi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .out_valid  (front_valid),
      .out_ready  (front_ready),
      .out_item   (front_item)
   );

   rsi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item),
      .status     (qstat)
   );

   rsi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (back_valid),
      .in_ready   (back_ready),
      .in_item    (back_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // the front only stalls on a full queue
   `RSI_ASSERT_IMPL(a_stall_on_full, clock, reset, !req_tready, qstat.full)
   // a front beat blocked by the queue stays put
   `RSI_ASSERT_NEXT(a_front_hold, clock, reset, front_valid && !front_ready, front_valid)
   // a miss or degenerate ray reports minus one and no clamp
   `RSI_ASSERT_IMPL(a_miss_value, clock, reset, rsp_tvalid && !rsp_tdata[0],
      (rsp_tdata[32:1] == MINUS_ONE) && !rsp_tdata[34])
   // a zero direction never reports a hit
   `RSI_ASSERT_IMPL(a_degen_miss, clock, reset, rsp_tvalid && rsp_tdata[33], !rsp_tdata[0])

endmodule

// ----- hw/rtl/rsi_front.sv -----
// Front pipeline: forms a, half_b, c and the discriminant and classifies each ray.
module rsi_front
   import rsi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  out_valid,
   input  logic                  out_ready,
   output front_item_type        out_item
);

   logic adv;
   logic [7:1] v_ff;

   // stage 1
   logic signed [OC_W-1:0]    oc_in [3], oc_ff [3];
   logic signed [COORD_W-1:0] d1_in [3], d1_ff [3];
   logic [RAD_W-1:0]          r1_ff;
   // stage 2
   logic signed [DD_W-1:0]    dd_in [3], dd_ff [3];
   logic signed [OD_W-1:0]    od_in [3], od_ff [3];
   logic signed [OO_W-1:0]    oo_in [3], oo_ff [3];
   logic [RR_W-1:0]           rr_in, rr_ff;
   // stage 3
   logic [A_W-1:0]            a3_in, a3_ff;
   logic signed [HB_W-1:0]    hb3_in, hb3_ff;
   logic signed [C_W-1:0]     c3_in, c3_ff;
   // stage 4
   logic [A_W-1:0]            a4_ff;
   logic signed [HB_W-1:0]    hb4_ff;
   logic [HBM_W-1:0]          hbm_in, hbm_ff;
   logic [CM_W-1:0]           cm_in, cm_ff;
   logic                      cneg4_ff, dg4_ff;
   // stage 5
   logic [A_W-1:0]            a5_ff;
   logic signed [HB_W-1:0]    hb5_ff;
   logic [2*HL_W-1:0]         p_ll_in, p_ll_ff;
   logic [HL_W+HH_W-1:0]      p_lh_in, p_lh_ff;
   logic [2*HH_W-1:0]         p_hh_in, p_hh_ff;
   logic [AH_W+CH_W-1:0]      q_hh_in, q_hh_ff;
   logic [AH_W+CL_W-1:0]      q_hl_in, q_hl_ff;
   logic [AL_W+CH_W-1:0]      q_lh_in, q_lh_ff;
   logic [AL_W+CL_W-1:0]      q_ll_in, q_ll_ff;
   logic                      cneg5_ff, dg5_ff;
   // stage 6
   logic [A_W-1:0]            a6_ff;
   logic signed [HB_W-1:0]    hb6_ff;
   logic [PROD_W-1:0]         hb2_in, hb2_ff, ac_in, ac_ff;
   logic                      cneg6_ff, dg6_ff;
   // stage 7
   logic [DISC_W-1:0]         disc_in, disc_ff;
   logic [A_W-1:0]            a7_ff;
   logic signed [HB_W-1:0]    hb7_ff;
   logic                      dg7_ff;

   // advance the whole pipeline unless the last stage is blocked
   assign adv        = !v_ff[7] || out_ready;
   assign req_tready = adv;

   // stage 1: offset from the sphere center
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         oc_in[i] = OC_W'($signed(req_tdata[i*COORD_W +: COORD_W]))
                  - OC_W'($signed(req_tdata[(6+i)*COORD_W +: COORD_W]));
         d1_in[i] = $signed(req_tdata[(3+i)*COORD_W +: COORD_W]);
      end
   end

   // stage 2: component products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dd_in[i] = DD_W'(d1_ff[i]) * DD_W'(d1_ff[i]);
         od_in[i] = OD_W'(oc_ff[i]) * OD_W'(d1_ff[i]);
         oo_in[i] = OO_W'(oc_ff[i]) * OO_W'(oc_ff[i]);
      end
      rr_in = RR_W'(r1_ff) * RR_W'(r1_ff);
   end

   // stage 3: dot products
   assign a3_in  = A_W'($unsigned(dd_ff[0])) + A_W'($unsigned(dd_ff[1]))
                 + A_W'($unsigned(dd_ff[2]));
   assign hb3_in = HB_W'(od_ff[0]) + HB_W'(od_ff[1]) + HB_W'(od_ff[2]);
   assign c3_in  = C_W'(oo_ff[0]) + C_W'(oo_ff[1]) + C_W'(oo_ff[2])
                 - $signed({{(C_W-RR_W){1'b0}}, rr_ff});

   // stage 4: magnitudes for the wide products
   always_comb begin
      logic signed [HB_W-1:0] hb_abs;
      logic signed [C_W-1:0]  c_abs;
      hb_abs = hb3_ff[HB_W-1] ? -hb3_ff : hb3_ff;
      c_abs  = c3_ff[C_W-1] ? -c3_ff : c3_ff;
      hbm_in = hb_abs[HBM_W-1:0];
      cm_in  = c_abs[CM_W-1:0];
   end

   // stage 5: partial products of half_b^2 and a*c
   assign p_ll_in = (2*HL_W)'(hbm_ff[HL_W-1:0]) * (2*HL_W)'(hbm_ff[HL_W-1:0]);
   assign p_lh_in = (HL_W+HH_W)'(hbm_ff[HL_W-1:0]) * (HL_W+HH_W)'(hbm_ff[HBM_W-1:HL_W]);
   assign p_hh_in = (2*HH_W)'(hbm_ff[HBM_W-1:HL_W]) * (2*HH_W)'(hbm_ff[HBM_W-1:HL_W]);
   assign q_hh_in = (AH_W+CH_W)'(a4_ff[A_W-1:AL_W]) * (AH_W+CH_W)'(cm_ff[CM_W-1:CL_W]);
   assign q_hl_in = (AH_W+CL_W)'(a4_ff[A_W-1:AL_W]) * (AH_W+CL_W)'(cm_ff[CL_W-1:0]);
   assign q_lh_in = (AL_W+CH_W)'(a4_ff[AL_W-1:0]) * (AL_W+CH_W)'(cm_ff[CM_W-1:CL_W]);
   assign q_ll_in = (AL_W+CL_W)'(a4_ff[AL_W-1:0]) * (AL_W+CL_W)'(cm_ff[CL_W-1:0]);

   // stage 6: assemble the full products
   assign hb2_in = (PROD_W'(p_hh_ff) << (2*HL_W))
                 + (PROD_W'(p_lh_ff) << (HL_W+1))
                 + PROD_W'(p_ll_ff);
   assign ac_in  = (PROD_W'(q_hh_ff) << (AL_W+CL_W))
                 + (PROD_W'(q_hl_ff) << AL_W)
                 + (PROD_W'(q_lh_ff) << CL_W)
                 + PROD_W'(q_ll_ff);

   // stage 7: discriminant
   assign disc_in = cneg6_ff ? DISC_W'(hb2_ff) + DISC_W'(ac_ff)
                             : DISC_W'(hb2_ff) - DISC_W'(ac_ff);

   // hold valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[6:1], req_tvalid};
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         oc_ff    <= oc_in;
         d1_ff    <= d1_in;
         r1_ff    <= req_tdata[9*COORD_W +: RAD_W];
         dd_ff    <= dd_in;
         od_ff    <= od_in;
         oo_ff    <= oo_in;
         rr_ff    <= rr_in;
         a3_ff    <= a3_in;
         hb3_ff   <= hb3_in;
         c3_ff    <= c3_in;
         a4_ff    <= a3_ff;
         hb4_ff   <= hb3_ff;
         hbm_ff   <= hbm_in;
         cm_ff    <= cm_in;
         cneg4_ff <= c3_ff[C_W-1];
         dg4_ff   <= (a3_ff == '0);
         a5_ff    <= a4_ff;
         hb5_ff   <= hb4_ff;
         p_ll_ff  <= p_ll_in;
         p_lh_ff  <= p_lh_in;
         p_hh_ff  <= p_hh_in;
         q_hh_ff  <= q_hh_in;
         q_hl_ff  <= q_hl_in;
         q_lh_ff  <= q_lh_in;
         q_ll_ff  <= q_ll_in;
         cneg5_ff <= cneg4_ff;
         dg5_ff   <= dg4_ff;
         a6_ff    <= a5_ff;
         hb6_ff   <= hb5_ff;
         hb2_ff   <= hb2_in;
         ac_ff    <= ac_in;
         cneg6_ff <= cneg5_ff;
         dg6_ff   <= dg5_ff;
         a7_ff    <= a6_ff;
         hb7_ff   <= hb6_ff;
         disc_ff  <= disc_in;
         dg7_ff   <= dg6_ff;
      end
   end

   assign out_valid      = v_ff[7];
   assign out_item.disc  = disc_ff;
   assign out_item.hb    = hb7_ff;
   assign out_item.a     = a7_ff;
   assign out_item.degen = dg7_ff;
   assign out_item.hit   = !dg7_ff && !disc_ff[DISC_W-1];

endmodule

// ----- hw/rtl/rsi_queue.sv -----
// Short register queue between the front and back pipelines.
module rsi_queue
   import rsi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  front_item_type   push_item,
   output logic             pop_valid,
   input  logic             pop_ready,
   output front_item_type   pop_item,
   output queue_status_type status
);

   front_item_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign push_ready   = !status.full;
   assign pop_valid    = !status.empty;
   assign pop_item     = slot_ff[rd_ptr_ff];

   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the incoming beat
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hw/rtl/rsi_back.sv -----
// Back pipeline: integer square root, nearer root division, clamping and output register.
module rsi_back
   import rsi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  front_item_type        in_item,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic adv;

   // square root stages
   logic [SQ_W+1:0]        sq_rem_ff [SQ_W+1], sq_rem_in [SQ_W+1];
   logic [SQ_W-1:0]        sq_root_ff [SQ_W+1], sq_root_in [SQ_W+1];
   logic [DISC_W-1:0]      sq_x_ff [SQ_W+1], sq_x_in [SQ_W+1];
   logic signed [HB_W-1:0] sq_hb_ff [SQ_W+1];
   logic [A_W-1:0]         sq_a_ff [SQ_W+1];
   logic [SQ_W:0]          sq_hit_ff, sq_dg_ff, sq_v_ff;

   // numerator stages
   logic signed [SUM_W-1:0] n1_sum_in, n1_sum_ff;
   logic [A_W-1:0]          n1_a_ff, n2_a_ff;
   logic                    n1_hit_ff, n1_dg_ff, n1_v_ff;
   logic [MAG_W-1:0]        n2_mag_in, n2_mag_ff;
   logic                    n2_neg_ff, n2_hit_ff, n2_dg_ff, n2_v_ff;

   // divide stages
   logic [NN_W-1:0]  nn;
   logic [A_W-1:0]   hi_ext;
   logic             ovf_in;
   logic [A_W-1:0]   dv_rem_ff [Q_W+1], dv_rem_in [Q_W+1];
   logic [Q_W-1:0]   dv_lo_ff [Q_W+1], dv_lo_in [Q_W+1];
   logic [Q_W-1:0]   dv_q_ff [Q_W+1], dv_q_in [Q_W+1];
   logic [A_W-1:0]   dv_a_ff [Q_W+1];
   logic [Q_W:0]     dv_neg_ff, dv_ovf_ff, dv_hit_ff, dv_dg_ff, dv_v_ff;

   // output register
   rsp_beat_type out_in, out_ff;
   logic         out_v_ff;

   assign adv      = !out_v_ff || rsp_tready;
   assign in_ready = adv;

   // one root bit per stage
   always_comb begin
      logic [SQ_W+1:0] t;
      logic [SQ_W+1:0] trial;
      sq_rem_in[0]  = '0;
      sq_root_in[0] = '0;
      sq_x_in[0]    = in_item.disc;
      for (int j = 0; j < SQ_W; j++) begin
         t     = {sq_rem_ff[j][SQ_W-1:0], sq_x_ff[j][DISC_W-1 -: 2]};
         trial = {sq_root_ff[j], 2'b01};
         if (t >= trial) begin
            sq_rem_in[j+1]  = t - trial;
            sq_root_in[j+1] = {sq_root_ff[j][SQ_W-2:0], 1'b1};
         end else begin
            sq_rem_in[j+1]  = t;
            sq_root_in[j+1] = {sq_root_ff[j][SQ_W-2:0], 1'b0};
         end
         sq_x_in[j+1] = {sq_x_ff[j][DISC_W-3:0], 2'b00};
      end
   end

   // numerator: -(half_b + root), split into sign and magnitude
   assign n1_sum_in = SUM_W'(sq_hb_ff[SQ_W]) + $signed({2'b00, sq_root_ff[SQ_W]});
   always_comb begin
      logic signed [SUM_W-1:0] s_abs;
      s_abs     = n1_sum_ff[SUM_W-1] ? -n1_sum_ff : n1_sum_ff;
      n2_mag_in = s_abs[MAG_W-1:0];
   end

   // scale by the fraction bits and check quotient range up front
   assign nn     = {n2_mag_ff, {FRAC_BITS{1'b0}}};
   assign hi_ext = A_W'(nn[NN_W-1:Q_W]);
   assign ovf_in = (hi_ext >= n2_a_ff);

   // one quotient bit per stage
   always_comb begin
      logic [A_W:0] t;
      dv_rem_in[0] = ovf_in ? '0 : hi_ext;
      dv_lo_in[0]  = nn[Q_W-1:0];
      dv_q_in[0]   = '0;
      for (int j = 0; j < Q_W; j++) begin
         t = {dv_rem_ff[j], dv_lo_ff[j][Q_W-1]};
         if (t >= {1'b0, dv_a_ff[j]}) begin
            dv_rem_in[j+1] = A_W'(t - {1'b0, dv_a_ff[j]});
            dv_q_in[j+1]   = {dv_q_ff[j][Q_W-2:0], 1'b1};
         end else begin
            dv_rem_in[j+1] = t[A_W-1:0];
            dv_q_in[j+1]   = {dv_q_ff[j][Q_W-2:0], 1'b0};
         end
         dv_lo_in[j+1] = {dv_lo_ff[j][Q_W-2:0], 1'b0};
      end
   end

   // clamp and pick the result
   always_comb begin
      logic [Q_W-1:0] limit;
      logic           over;
      limit = dv_neg_ff[Q_W] ? NEG_LIMIT : POS_LIMIT;
      over  = dv_ovf_ff[Q_W] || (dv_q_ff[Q_W] > limit);
      out_in.hit        = dv_hit_ff[Q_W];
      out_in.degenerate = dv_dg_ff[Q_W];
      out_in.saturated  = dv_hit_ff[Q_W] && over;
      if (!dv_hit_ff[Q_W]) begin
         out_in.hit_distance = MINUS_ONE;
      end else if (over) begin
         out_in.hit_distance = limit;
      end else if (dv_neg_ff[Q_W]) begin
         out_in.hit_distance = -dv_q_ff[Q_W];
      end else begin
         out_in.hit_distance = dv_q_ff[Q_W];
      end
   end

   // hold valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff  <= '0;
         n1_v_ff  <= 1'b0;
         n2_v_ff  <= 1'b0;
         dv_v_ff  <= '0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         sq_v_ff  <= {sq_v_ff[SQ_W-1:0], in_valid};
         n1_v_ff  <= sq_v_ff[SQ_W];
         n2_v_ff  <= n1_v_ff;
         dv_v_ff  <= {dv_v_ff[Q_W-1:0], n2_v_ff};
         out_v_ff <= dv_v_ff[Q_W];
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         sq_rem_ff  <= sq_rem_in;
         sq_root_ff <= sq_root_in;
         sq_x_ff    <= sq_x_in;
         sq_hb_ff[0] <= in_item.hb;
         sq_a_ff[0]  <= in_item.a;
         for (int j = 0; j < SQ_W; j++) begin
            sq_hb_ff[j+1] <= sq_hb_ff[j];
            sq_a_ff[j+1]  <= sq_a_ff[j];
         end
         sq_hit_ff <= {sq_hit_ff[SQ_W-1:0], in_item.hit};
         sq_dg_ff  <= {sq_dg_ff[SQ_W-1:0], in_item.degen};
         n1_sum_ff <= n1_sum_in;
         n1_a_ff   <= sq_a_ff[SQ_W];
         n1_hit_ff <= sq_hit_ff[SQ_W];
         n1_dg_ff  <= sq_dg_ff[SQ_W];
         n2_mag_ff <= n2_mag_in;
         n2_neg_ff <= !n1_sum_ff[SUM_W-1] && (n1_sum_ff != '0);
         n2_a_ff   <= n1_a_ff;
         n2_hit_ff <= n1_hit_ff;
         n2_dg_ff  <= n1_dg_ff;
         dv_rem_ff <= dv_rem_in;
         dv_lo_ff  <= dv_lo_in;
         dv_q_ff   <= dv_q_in;
         dv_a_ff[0] <= n2_a_ff;
         for (int j = 0; j < Q_W; j++) begin
            dv_a_ff[j+1] <= dv_a_ff[j];
         end
         dv_neg_ff <= {dv_neg_ff[Q_W-1:0], n2_neg_ff};
         dv_ovf_ff <= {dv_ovf_ff[Q_W-1:0], ovf_in};
         dv_hit_ff <= {dv_hit_ff[Q_W-1:0], n2_hit_ff};
         dv_dg_ff  <= {dv_dg_ff[Q_W-1:0], n2_dg_ff};
         out_ff    <= out_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {(RSP_DATA_W-$bits(rsp_beat_type))'(0), out_ff};

endmodule
